### rtl/aldb_pkg.sv
// ----------------------------------------------------------------------------
// aldb_pkg
// Shared types and constants of the ladder keypad debounce block.
// ----------------------------------------------------------------------------
package aldb_pkg;

	localparam int ENTRY_COUNT  = 6;
	localparam int ENTRY_BITS   = 28;
	localparam int PAIR_BITS    = 2 * ENTRY_BITS;
	localparam int BOUND_BITS   = 12;
	localparam int CODE_BITS    = 3;
	localparam int REPEAT_BITS  = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int QUEUE_DEPTH  = 2;

	// Entry layout
	localparam int ENT_MIN_LSB  = 0;
	localparam int ENT_MAX_LSB  = 12;
	localparam int ENT_CHAN_BIT = 24;
	localparam int ENT_CODE_LSB = 25;

	typedef logic [CODE_BITS-1:0]   button_t;
	typedef logic [1:0]             cause_t;
	typedef logic [REPEAT_BITS-1:0] repeat_t;

	localparam button_t BTN_NONE     = 3'd0;
	localparam button_t BTN_CODE_MAX = 3'd6;
	localparam repeat_t REPEAT_MAX   = 8'd255;

	localparam cause_t CAUSE_CONFIRMED = 2'd0;
	localparam cause_t CAUSE_QUICK     = 2'd1;
	localparam cause_t CAUSE_TIMEOUT   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_LEVEL   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_QUICK        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRIES_0    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRIES_1    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRIES_2    = 3'd6;

	// Settings used by the decoder
	typedef struct packed {
		logic [BOUND_BITS-1:0]                   idle_level;
		logic [ENTRY_COUNT-1:0][ENTRY_BITS-1:0]  entries;
	} front_cfg_t;

	// Settings used by the session sequencer
	typedef struct packed {
		repeat_t     confirm_count;
		logic [15:0] window_samples;
		logic [15:0] quick_samples;
	} back_cfg_t;

	// One decoded sample in the queue
	typedef struct packed {
		logic    start;
		button_t code;
	} item_t;

endpackage

### rtl/aldb_if.sv
// ----------------------------------------------------------------------------
// aldb_if
// Handshake channels: sample input, result output, register writes.
// ----------------------------------------------------------------------------
interface aldb_in_if #(parameter int ADC_BITS = 12);
	logic                valid;
	logic                ready;
	logic                start_req;
	logic [ADC_BITS-1:0] level_first;
	logic [ADC_BITS-1:0] level_second;

	modport source (output valid, start_req, level_first, level_second, input ready);
	modport sink   (input valid, start_req, level_first, level_second, output ready);
endinterface

interface aldb_out_if;
	logic                valid;
	logic                ready;
	aldb_pkg::button_t   button;
	aldb_pkg::cause_t    end_cause;

	modport source (output valid, button, end_cause, input ready);
	modport sink   (input valid, button, end_cause, output ready);
endinterface

interface aldb_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [aldb_pkg::CFG_IDX_BITS-1:0]   index;
	logic [aldb_pkg::PAIR_BITS-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/aldb_front.sv
// ----------------------------------------------------------------------------
// aldb_front
// Takes sample beats and decodes them to a button code for the queue.
// ----------------------------------------------------------------------------
module aldb_front #(
	parameter int ADC_BITS = 12
) (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 start_req,
	input  logic [ADC_BITS-1:0]  level_first,
	input  logic [ADC_BITS-1:0]  level_second,
	input  aldb_pkg::front_cfg_t cfg,
	output logic                 push,
	output aldb_pkg::item_t      push_item,
	input  logic                 queue_full
);

	localparam int CMP_W = (ADC_BITS > aldb_pkg::BOUND_BITS) ? ADC_BITS : aldb_pkg::BOUND_BITS;

	logic [ADC_BITS-1:0]    idle_m;
	logic                   idle;
	aldb_pkg::button_t      code;

	assign idle_m = ADC_BITS'(cfg.idle_level);
	assign idle   = (level_first > idle_m) && (level_second > idle_m);

	// Six range checks in parallel, lowest entry wins
	always_comb begin
		logic [aldb_pkg::ENTRY_BITS-1:0] e;
		logic [CMP_W-1:0]                lvl;
		logic [CMP_W-1:0]                lo;
		logic [CMP_W-1:0]                hi;
		aldb_pkg::button_t               c;
		code = aldb_pkg::BTN_NONE;
		for (int k = aldb_pkg::ENTRY_COUNT - 1; k >= 0; k--) begin
			e   = cfg.entries[k];
			lo  = CMP_W'(e[aldb_pkg::ENT_MIN_LSB +: aldb_pkg::BOUND_BITS]);
			hi  = CMP_W'(e[aldb_pkg::ENT_MAX_LSB +: aldb_pkg::BOUND_BITS]);
			lvl = e[aldb_pkg::ENT_CHAN_BIT] ? CMP_W'(level_second) : CMP_W'(level_first);
			c   = e[aldb_pkg::ENT_CODE_LSB +: aldb_pkg::CODE_BITS];
			if (lvl > lo && lvl <= hi && c != aldb_pkg::BTN_NONE
			    && c <= aldb_pkg::BTN_CODE_MAX) begin
				code = c;
			end
		end
		if (idle) begin
			code = aldb_pkg::BTN_NONE;
		end
	end

	assign in_ready        = !queue_full;
	assign push            = in_valid && !queue_full;
	assign push_item.start = start_req;
	assign push_item.code  = code;

endmodule

### rtl/aldb_queue.sv
// ----------------------------------------------------------------------------
// aldb_queue
// Short FIFO of decoded samples between decoder and sequencer.
// ----------------------------------------------------------------------------
module aldb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aldb_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output aldb_pkg::item_t head
);

	localparam int PTR_W = (aldb_pkg::QUEUE_DEPTH > 1) ? $clog2(aldb_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(aldb_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(aldb_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(aldb_pkg::QUEUE_DEPTH - 1);

	aldb_pkg::item_t   slot_q [aldb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == DEPTH_C);
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_C) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_C) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

### rtl/aldb_back.sv
// ----------------------------------------------------------------------------
// aldb_back
// Session sequencer: repeat counting, window timing, result register.
// ----------------------------------------------------------------------------
module aldb_back #(
	parameter int TIME_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aldb_pkg::back_cfg_t cfg,
	input  logic                not_empty,
	input  aldb_pkg::item_t     head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output aldb_pkg::button_t   button,
	output aldb_pkg::cause_t    end_cause
);

	localparam int TW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

	logic                  active_q;
	aldb_pkg::button_t     prev_q;
	aldb_pkg::repeat_t     rep_q;
	logic [TIME_BITS-1:0]  idx_q;
	logic                  out_valid_q;
	aldb_pkg::button_t     button_q;
	aldb_pkg::cause_t      cause_q;

	logic                  act;
	aldb_pkg::button_t     prev_b;
	aldb_pkg::repeat_t     rep_b;
	logic [TIME_BITS-1:0]  idx_b;
	aldb_pkg::button_t     prev_n;
	aldb_pkg::repeat_t     rep_n;
	logic                  hit_confirm;
	logic                  hit_quick;
	logic                  hit_timeout;
	logic                  done;
	logic [TW-1:0]         idx_x;

	// Start wipes the running session
	assign act    = head.start || active_q;
	assign prev_b = head.start ? aldb_pkg::BTN_NONE : prev_q;
	assign rep_b  = head.start ? '0 : rep_q;
	assign idx_b  = head.start ? '0 : idx_q;
	assign idx_x  = TW'(idx_b);

	always_comb begin
		hit_confirm = 1'b0;
		hit_quick   = 1'b0;
		prev_n      = aldb_pkg::BTN_NONE;
		rep_n       = '0;
		if (head.code != aldb_pkg::BTN_NONE) begin
			prev_n = head.code;
			if (head.code == prev_b) begin
				rep_n       = (rep_b < aldb_pkg::REPEAT_MAX) ? rep_b + 1'b1 : rep_b;
				hit_confirm = (rep_n >= cfg.confirm_count);
			end else begin
				rep_n = 8'd1;
			end
		end else begin
			hit_quick = (idx_x > TW'(cfg.quick_samples));
		end
		hit_timeout = ((idx_x + 1'b1) >= TW'(cfg.window_samples));
	end

	assign done = act && (hit_confirm || hit_quick || hit_timeout);
	assign pop  = not_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			prev_q      <= aldb_pkg::BTN_NONE;
			rep_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (done) begin
					active_q <= 1'b0;
					prev_q   <= aldb_pkg::BTN_NONE;
					rep_q    <= '0;
					idx_q    <= '0;
				end else if (act) begin
					active_q <= 1'b1;
					prev_q   <= prev_n;
					rep_q    <= rep_n;
					idx_q    <= (idx_b != '1) ? idx_b + 1'b1 : idx_b;
				end
			end
			if (pop && done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && done) begin
			button_q <= hit_confirm ? head.code : aldb_pkg::BTN_NONE;
			cause_q  <= hit_confirm ? aldb_pkg::CAUSE_CONFIRMED :
			            hit_quick   ? aldb_pkg::CAUSE_QUICK : aldb_pkg::CAUSE_TIMEOUT;
		end
	end

	assign out_valid = out_valid_q;
	assign button    = button_q;
	assign end_cause = cause_q;

endmodule

### rtl/adc_ladder_button_debounce_unit.sv
// ----------------------------------------------------------------------------
// adc_ladder_button_debounce_unit
// Resistor-ladder keypad reader with per-session debounce.
// ----------------------------------------------------------------------------
// One sample beat (two ladder channel levels plus a start flag) is taken every
// clock cycle while the two-entry queue has room. The front decodes each beat
// against the idle level and the six range entries in the same cycle and
// queues the button code; the back advances the session once per queued beat
// and ends it with at most one result beat: a confirmed button, an idle exit
// after the quick window, or a timeout at the end of the window. A result
// passes through a queue slot and then the result register on its way from
// the sample beat that caused it. A result waiting on the output does not
// block intake until the queue fills. Register writes are always accepted;
// they are meant to be made while no session is running.
// ----------------------------------------------------------------------------
module adc_ladder_button_debounce_unit #(
	parameter int ADC_BITS  = 12,
	parameter int TIME_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	aldb_cfg_if.sink     cfg,
	aldb_in_if.sink      sample,
	aldb_out_if.source   result
);

	// register file
	logic [aldb_pkg::BOUND_BITS-1:0]   idle_level_q;
	aldb_pkg::repeat_t                 confirm_q;
	logic [15:0]                       window_q;
	logic [15:0]                       quick_q;
	logic [2:0][aldb_pkg::PAIR_BITS-1:0] pairs_q;

	aldb_pkg::front_cfg_t  front_cfg;
	aldb_pkg::back_cfg_t   back_cfg;

	logic                  push;
	aldb_pkg::item_t       push_item;
	logic                  queue_full;
	logic                  pop;
	logic                  not_empty;
	aldb_pkg::item_t       head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q <= 12'd4095;
			confirm_q    <= 8'd3;
			window_q     <= 16'd100;
			quick_q      <= 16'd20;
			pairs_q      <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				aldb_pkg::CFG_IDLE_LEVEL: idle_level_q <= cfg.data[aldb_pkg::BOUND_BITS-1:0];
				aldb_pkg::CFG_CONFIRM:    confirm_q    <= cfg.data[aldb_pkg::REPEAT_BITS-1:0];
				aldb_pkg::CFG_WINDOW:     window_q     <= cfg.data[15:0];
				aldb_pkg::CFG_QUICK:      quick_q      <= cfg.data[15:0];
				aldb_pkg::CFG_ENTRIES_0:  pairs_q[0]   <= cfg.data;
				aldb_pkg::CFG_ENTRIES_1:  pairs_q[1]   <= cfg.data;
				aldb_pkg::CFG_ENTRIES_2:  pairs_q[2]   <= cfg.data;
				default: begin
					// unmapped index: beat dropped
				end
			endcase
		end
	end

	// pairs unpack low entry first
	always_comb begin
		front_cfg.idle_level = idle_level_q;
		for (int k = 0; k < aldb_pkg::ENTRY_COUNT; k++) begin
			front_cfg.entries[k] = pairs_q[k/2][(k%2)*aldb_pkg::ENTRY_BITS +: aldb_pkg::ENTRY_BITS];
		end
	end

	assign back_cfg.confirm_count  = confirm_q;
	assign back_cfg.window_samples = window_q;
	assign back_cfg.quick_samples  = quick_q;

	aldb_front #(
		.ADC_BITS(ADC_BITS)
	) u_front (
		.in_valid    (sample.valid),
		.in_ready    (sample.ready),
		.start_req   (sample.start_req),
		.level_first (sample.level_first),
		.level_second(sample.level_second),
		.cfg         (front_cfg),
		.push        (push),
		.push_item   (push_item),
		.queue_full  (queue_full)
	);

	aldb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	aldb_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.button    (result.button),
		.end_cause (result.end_cause)
	);

endmodule

### rtl/aldb_checker.sv
// ----------------------------------------------------------------------------
// aldb_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module aldb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input aldb_pkg::button_t button,
	input aldb_pkg::cause_t  end_cause
);

	// stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(button) && $stable(end_cause))
		else $error("result beat changed while stalled");

	// idle exit and timeout carry no button
	a_no_button: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_cause != aldb_pkg::CAUSE_CONFIRMED |-> button == aldb_pkg::BTN_NONE)
		else $error("button reported on non-confirm end");

	// a confirmation names a real button
	a_confirm_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_cause == aldb_pkg::CAUSE_CONFIRMED |->
		button != aldb_pkg::BTN_NONE && button <= aldb_pkg::BTN_CODE_MAX)
		else $error("confirmation without valid button code");

endmodule

bind adc_ladder_button_debounce_unit aldb_checker u_aldb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.button    (result.button),
	.end_cause (result.end_cause)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ladder keypad debounce unit. Sample beats go in
// through a valid/ready channel, and both sides idle and stall at random. A
// session predictor in the bench works out the result beat that each sample
// should cause, and every result beat is checked field by field against the
// oldest expected outcome. Settings change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADC_W         = 12;
	localparam int TIME_W        = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_LIMIT   = 4000;
	// result follows its sample through a queue slot and the result register; leave slack on top
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int MAX_WAIT      = 9;

	localparam bit [ADC_W-1:0] LEVEL_TOP   = '1;
	localparam bit [ADC_W-1:0] LADDER_IDLE = 12'd3600;

	typedef struct packed {
		aldb_pkg::button_t button;
		aldb_pkg::cause_t  cause;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	aldb_cfg_if                   cfg_ch ();
	aldb_in_if #(.ADC_BITS(ADC_W)) sample_ch ();
	aldb_out_if                   result_ch ();

	adc_ladder_button_debounce_unit #(
		.ADC_BITS  (ADC_W),
		.TIME_BITS (TIME_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.result (result_ch)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the settings and of the session state
	// ------------------------------------------------------------------
	bit [ADC_W-1:0]               keypad_idle;
	bit [7:0]                     keypad_confirm;
	bit [TIME_W-1:0]              keypad_window;
	bit [TIME_W-1:0]              keypad_quick;
	bit [aldb_pkg::PAIR_BITS-1:0] keypad_pairs [3];

	bit                 sess_open;
	aldb_pkg::button_t  last_code;
	bit [7:0]           run_len;
	bit [TIME_W-1:0]    sample_pos;

	outcome_t expected_outcomes [$];

	int  fail_count;
	int  cycle_count;
	bit  in_idle_on;   // sender may leave gaps between beats
	bit  out_idle_on;  // receiver may stall before taking a result

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic bit [aldb_pkg::ENTRY_BITS-1:0] entry_at(input int k);
		return aldb_pkg::ENTRY_BITS'(keypad_pairs[k / 2] >> ((k % 2) * aldb_pkg::ENTRY_BITS));
	endfunction

	function automatic bit [aldb_pkg::ENTRY_BITS-1:0] make_entry(input bit [11:0] lo,
			input bit [11:0] hi, input bit chan, input aldb_pkg::button_t code);
		return {code, chan, hi, lo};
	endfunction

	// Idle check first, then the first entry in table order whose range holds
	// the level of its channel. Lower bound exclusive, upper bound inclusive.
	function automatic aldb_pkg::button_t decode_levels(input bit [ADC_W-1:0] first,
			input bit [ADC_W-1:0] second);
		bit [aldb_pkg::ENTRY_BITS-1:0] ent;
		bit [11:0]           lo;
		bit [11:0]           hi;
		bit [ADC_W-1:0]      lvl;
		aldb_pkg::button_t   code;
		aldb_pkg::button_t   found;
		found = aldb_pkg::BTN_NONE;
		if (first > keypad_idle && second > keypad_idle)
			return aldb_pkg::BTN_NONE;
		for (int k = 0; k < aldb_pkg::ENTRY_COUNT; k++) begin
			ent  = entry_at(k);
			lo   = ent[aldb_pkg::ENT_MIN_LSB +: aldb_pkg::BOUND_BITS];
			hi   = ent[aldb_pkg::ENT_MAX_LSB +: aldb_pkg::BOUND_BITS];
			lvl  = ent[aldb_pkg::ENT_CHAN_BIT] ? second : first;
			code = ent[aldb_pkg::ENT_CODE_LSB +: aldb_pkg::CODE_BITS];
			// codes 0 and 7 mark unused slots
			if (found == aldb_pkg::BTN_NONE && lvl > lo && lvl <= hi
					&& code != aldb_pkg::BTN_NONE && code <= aldb_pkg::BTN_CODE_MAX)
				found = code;
		end
		return found;
	endfunction

	// Advances the session by one sample; returns 1 when the session ends.
	function automatic bit advance_session(input bit start, input bit [ADC_W-1:0] first,
			input bit [ADC_W-1:0] second, output aldb_pkg::button_t btn,
			output aldb_pkg::cause_t cause);
		aldb_pkg::button_t cur;
		bit      done;
		done  = 1'b0;
		btn   = aldb_pkg::BTN_NONE;
		cause = aldb_pkg::CAUSE_CONFIRMED;
		if (start) begin
			// a start mid-session simply drops the old one
			sess_open  = 1'b1;
			last_code  = aldb_pkg::BTN_NONE;
			run_len    = '0;
			sample_pos = '0;
		end
		if (!sess_open)
			return 1'b0;
		cur = decode_levels(first, second);
		if (cur != aldb_pkg::BTN_NONE) begin
			if (cur == last_code) begin
				if (run_len != aldb_pkg::REPEAT_MAX)
					run_len++;
				if (run_len >= keypad_confirm) begin
					done  = 1'b1;
					btn   = cur;
					cause = aldb_pkg::CAUSE_CONFIRMED;
				end
			end else begin
				// first sight of a button is never checked, so two samples minimum
				last_code = cur;
				run_len   = 8'd1;
			end
		end else begin
			last_code = aldb_pkg::BTN_NONE;
			run_len   = '0;
			if (sample_pos > keypad_quick) begin
				done  = 1'b1;
				cause = aldb_pkg::CAUSE_QUICK;
			end
		end
		// window of 0 behaves as 1 thanks to the >= compare
		if (!done && ({1'b0, sample_pos} + 17'd1) >= {1'b0, keypad_window}) begin
			done  = 1'b1;
			cause = aldb_pkg::CAUSE_TIMEOUT;
		end
		if (done) begin
			sess_open  = 1'b0;
			last_code  = aldb_pkg::BTN_NONE;
			run_len    = '0;
			sample_pos = '0;
			return 1'b1;
		end
		if (sample_pos != '1)
			sample_pos++;
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Channel helpers
	// ------------------------------------------------------------------
	function automatic int draw_wait(input bit enabled);
		return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	function automatic bit [ADC_W-1:0] any_level();
		return ADC_W'($urandom_range(0, 4095));
	endfunction

	// Leaves valid high on return so that a back-to-back beat needs no toggle.
	task automatic send_sample(input bit start, input bit [ADC_W-1:0] first,
			input bit [ADC_W-1:0] second);
		int                gap;
		aldb_pkg::button_t btn;
		aldb_pkg::cause_t  cause;
		outcome_t          item;
		gap = draw_wait(in_idle_on);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.start_req    <= start;
		sample_ch.level_first  <= first;
		sample_ch.level_second <= second;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		if (advance_session(start, first, second, btn, cause)) begin
			item.button = btn;
			item.cause  = cause;
			expected_outcomes.push_back(item);
		end
	endtask

	// Waits for every expected beat, then lets beats that cause nothing clear
	// out of the queue before anything touches the registers.
	task automatic wait_drain();
		int waited;
		waited = 0;
		sample_ch.valid <= 1'b0;
		while (expected_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [aldb_pkg::CFG_IDX_BITS-1:0] idx,
			input bit [aldb_pkg::PAIR_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			aldb_pkg::CFG_IDLE_LEVEL: keypad_idle     = value[ADC_W-1:0];
			aldb_pkg::CFG_CONFIRM:    keypad_confirm  = value[7:0];
			aldb_pkg::CFG_WINDOW:     keypad_window   = value[TIME_W-1:0];
			aldb_pkg::CFG_QUICK:      keypad_quick    = value[TIME_W-1:0];
			aldb_pkg::CFG_ENTRIES_0:  keypad_pairs[0] = value;
			aldb_pkg::CFG_ENTRIES_1:  keypad_pairs[1] = value;
			aldb_pkg::CFG_ENTRIES_2:  keypad_pairs[2] = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input bit [ADC_W-1:0] idle, input bit [7:0] confirm,
			input bit [TIME_W-1:0] window, input bit [TIME_W-1:0] quick,
			input bit [aldb_pkg::PAIR_BITS-1:0] p0, input bit [aldb_pkg::PAIR_BITS-1:0] p1,
			input bit [aldb_pkg::PAIR_BITS-1:0] p2);
		wait_drain();
		write_reg(aldb_pkg::CFG_IDLE_LEVEL, aldb_pkg::PAIR_BITS'(idle));
		write_reg(aldb_pkg::CFG_CONFIRM, aldb_pkg::PAIR_BITS'(confirm));
		write_reg(aldb_pkg::CFG_WINDOW, aldb_pkg::PAIR_BITS'(window));
		write_reg(aldb_pkg::CFG_QUICK, aldb_pkg::PAIR_BITS'(quick));
		write_reg(aldb_pkg::CFG_ENTRIES_0, p0);
		write_reg(aldb_pkg::CFG_ENTRIES_1, p1);
		write_reg(aldb_pkg::CFG_ENTRIES_2, p2);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Table and level generators
	// ------------------------------------------------------------------
	// Four ranges on the first channel, two on the second, no spare slots.
	function automatic bit [aldb_pkg::PAIR_BITS-1:0] ladder_pair(input int n);
		case (n)
			0: return {make_entry(12'd1800, 12'd2600, 1'b0, 3'd2),
				make_entry(12'd2600, 12'd3500, 1'b0, 3'd1)};
			1: return {make_entry(12'd0, 12'd900, 1'b0, 3'd4),
				make_entry(12'd900, 12'd1800, 1'b0, 3'd3)};
			default:
				return {make_entry(12'd0, 12'd1500, 1'b1, 3'd6),
					make_entry(12'd1500, 12'd3000, 1'b1, 3'd5)};
		endcase
	endfunction

	// Random pair; may hold empty ranges, overlaps and unused codes. With
	// keep_upper set the upper entry is always a usable button.
	function automatic bit [aldb_pkg::PAIR_BITS-1:0] random_pair(input bit keep_upper);
		bit [11:0]         lo [2];
		bit [11:0]         hi [2];
		aldb_pkg::button_t code [2];
		for (int k = 0; k < 2; k++) begin
			lo[k]   = 12'($urandom_range(0, 4095));
			hi[k]   = 12'($urandom_range(0, 4095));
			code[k] = 3'($urandom_range(0, 7));
		end
		if (keep_upper) begin
			lo[1]   = 12'($urandom_range(0, 4000));
			hi[1]   = 12'($urandom_range(lo[1] + 1, 4095));
			code[1] = 3'($urandom_range(1, 6));
		end
		return {make_entry(lo[1], hi[1], 1'($urandom_range(0, 1)), code[1]),
			make_entry(lo[0], hi[0], 1'($urandom_range(0, 1)), code[0])};
	endfunction

	// Levels that sit on range edges, on the idle level, or anywhere at all.
	function automatic void pick_levels(output bit [ADC_W-1:0] first,
			output bit [ADC_W-1:0] second);
		bit [aldb_pkg::ENTRY_BITS-1:0] ent;
		bit [11:0]           lo;
		bit [11:0]           hi;
		bit [ADC_W-1:0]      lvl;
		bit [ADC_W-1:0]      other;
		int                  r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			ent = entry_at($urandom_range(0, aldb_pkg::ENTRY_COUNT - 1));
			lo  = ent[aldb_pkg::ENT_MIN_LSB +: aldb_pkg::BOUND_BITS];
			hi  = ent[aldb_pkg::ENT_MAX_LSB +: aldb_pkg::BOUND_BITS];
			case ($urandom_range(0, 4))
				0: lvl = lo;
				1: lvl = lo + 12'd1;
				2: lvl = hi;
				3: lvl = hi + 12'd1;
				default: lvl = ADC_W'($urandom_range(lo, hi));
			endcase
			case ($urandom_range(0, 2))
				0: other = LEVEL_TOP;
				1: other = '0;
				default: other = any_level();
			endcase
			if (ent[aldb_pkg::ENT_CHAN_BIT]) begin
				first  = other;
				second = lvl;
			end else begin
				first  = lvl;
				second = other;
			end
		end else if (r < 8) begin
			first  = ($urandom_range(0, 1) != 0) ? keypad_idle + 12'd1 : keypad_idle;
			second = ($urandom_range(0, 1) != 0) ? LEVEL_TOP : keypad_idle + 12'd1;
		end else begin
			first  = any_level();
			second = any_level();
		end
	endfunction

	// A pair that always decodes to a button: the top of the first usable
	// range on its channel, the other channel at zero so it is never idle.
	function automatic void steady_press(output bit [ADC_W-1:0] first,
			output bit [ADC_W-1:0] second);
		bit [aldb_pkg::ENTRY_BITS-1:0] ent;
		bit                  found;
		found  = 1'b0;
		first  = '0;
		second = '0;
		for (int k = 0; k < aldb_pkg::ENTRY_COUNT; k++) begin
			ent = entry_at(k);
			if (!found && ent[aldb_pkg::ENT_MAX_LSB +: aldb_pkg::BOUND_BITS]
					> ent[aldb_pkg::ENT_MIN_LSB +: aldb_pkg::BOUND_BITS]
					&& ent[aldb_pkg::ENT_CODE_LSB +: aldb_pkg::CODE_BITS] != aldb_pkg::BTN_NONE
					&& ent[aldb_pkg::ENT_CODE_LSB +: aldb_pkg::CODE_BITS]
					<= aldb_pkg::BTN_CODE_MAX) begin
				found = 1'b1;
				if (ent[aldb_pkg::ENT_CHAN_BIT])
					second = ent[aldb_pkg::ENT_MAX_LSB +: aldb_pkg::BOUND_BITS];
				else
					first = ent[aldb_pkg::ENT_MAX_LSB +: aldb_pkg::BOUND_BITS];
			end
		end
	endfunction

	// Mostly whole sessions: a start, then held or changing presses, with the
	// odd restart and stray beats between sessions. Past press_cap samples a
	// session is pushed to a confirmation so every session closes.
	task automatic run_sessions(input int n_items, input int hold_pct, input int press_cap);
		int             sent;
		int             in_sess;
		int             r;
		bit [ADC_W-1:0] first;
		bit [ADC_W-1:0] second;
		sent = 0;
		while (sent < n_items) begin
			if (sent % 40 < 2) begin
				in_idle_on  = $urandom_range(0, 3) != 0;
				out_idle_on = $urandom_range(0, 3) != 0;
			end
			pick_levels(first, second);
			if ($urandom_range(0, 9) == 0) begin
				// outside a session: ignored, so not counted
				send_sample(1'b0, first, second);
			end else begin
				send_sample(1'b1, first, second);
				sent++;
				in_sess = 1;
				while (sess_open) begin
					r = $urandom_range(0, 99);
					if (in_sess > press_cap) begin
						steady_press(first, second);
						send_sample(1'b0, first, second);
					end else if (r < hold_pct) begin
						send_sample(1'b0, first, second);
					end else if (r < hold_pct + 3) begin
						pick_levels(first, second);
						send_sample(1'b1, first, second);
						in_sess = 0;
					end else begin
						pick_levels(first, second);
						send_sample(1'b0, first, second);
					end
					sent++;
					in_sess++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset settings: empty table, so every sample is "no button" and the
	// session can only leave through the quick window (index 21).
	task automatic test_reset_settings();
		in_idle_on  = 1'b1;
		out_idle_on = 1'b1;
		send_sample(1'b0, any_level(), any_level());
		send_sample(1'b1, LEVEL_TOP, LEVEL_TOP);
		repeat (21)
			send_sample(1'b0, any_level(), any_level());
	endtask

	// Ranges of codes 1, 2, 3 and 5, mostly on their edges; confirm count 2 means press, repeat, done.
	task automatic test_ladder_codes();
		apply_settings(LADDER_IDLE, 8'd2, 16'd6, 16'd2,
			ladder_pair(0), ladder_pair(1), ladder_pair(2));
		send_sample(1'b1, 12'd3000, LEVEL_TOP);
		send_sample(1'b0, 12'd3000, LEVEL_TOP);
		send_sample(1'b1, 12'd2600, LEVEL_TOP);
		send_sample(1'b0, 12'd1800, LEVEL_TOP);
		send_sample(1'b0, 12'd1800, LEVEL_TOP);
		send_sample(1'b1, LEVEL_TOP, 12'd3000);
		send_sample(1'b0, LEVEL_TOP, 12'd3000);
	endtask

	// Both channels at zero decode to nothing; a start mid-press restarts.
	task automatic test_restart();
		send_sample(1'b1, 12'd0, 12'd0);
		send_sample(1'b0, 12'd500, LEVEL_TOP);
		send_sample(1'b1, 12'd500, LEVEL_TOP);
		send_sample(1'b0, 12'd500, LEVEL_TOP);
	endtask

	task automatic test_quick_exit();
		repeat (2) begin
			send_sample(1'b1, LEVEL_TOP, LEVEL_TOP);
			repeat (3) send_sample(1'b0, LEVEL_TOP, LEVEL_TOP);
		end
	endtask

	// Presses keep changing, so the last index of the window times out.
	task automatic test_timeout();
		send_sample(1'b1, LEVEL_TOP, 12'd1500);
		send_sample(1'b0, LEVEL_TOP, 12'd1501);
		send_sample(1'b0, LEVEL_TOP, 12'd1);
		send_sample(1'b0, LEVEL_TOP, 12'd3000);
		send_sample(1'b0, LEVEL_TOP, 12'd1);
		send_sample(1'b0, LEVEL_TOP, 12'd2999);
	endtask

	// Window 0 (acts as 1), idle level 0, upper pair all ones (code 7 slots).
	task automatic test_window_extremes();
		apply_settings('0, 8'd1, '0, '0, ladder_pair(0), ladder_pair(1), '1);
		run_sessions(40, 50, 30);
	endtask

	task automatic test_random_ladder();
		apply_settings(LADDER_IDLE, 8'd2, 16'd12, 16'd4,
			ladder_pair(0), ladder_pair(1), ladder_pair(2));
		run_sessions(40, 60, 30);
	endtask

	// Random tables, quick window never reached within a short window.
	task automatic test_random_tables();
		apply_settings(any_level(), 8'($urandom_range(3, 5)), 16'd30, '1,
			random_pair(1'b0), random_pair(1'b0), random_pair(1'b1));
		run_sessions(40, 70, 30);
	endtask

	// Largest confirm count with the longest window and no quick margin.
	task automatic test_long_confirm();
		apply_settings(LEVEL_TOP, 8'd255, '1, '0,
			ladder_pair(0), ladder_pair(1), ladder_pair(2));
		run_sessions(260, 95, 20);
	endtask

	task automatic test_random_mix();
		repeat (2) begin
			apply_settings(any_level(), 8'($urandom_range(0, 8)),
				16'($urandom_range(1, 40)), 16'($urandom_range(0, 40)),
				random_pair(1'b0), random_pair(1'b0), random_pair(1'b1));
			run_sessions(50, 55, 30);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, one draw per result beat
	// ------------------------------------------------------------------
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(out_idle_on);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
		end
	end

	// Every accepted result beat is matched against the oldest outcome.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_outcomes.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result beat: button %0d cause %0d",
						result_ch.button, result_ch.end_cause);
			end else begin
				want = expected_outcomes.pop_front();
				if (result_ch.button !== want.button || result_ch.end_cause !== want.cause) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("result mismatch: expected button %0d cause %0d, got button %0d cause %0d",
							want.button, want.cause, result_ch.button, result_ch.end_cause);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		sample_ch.valid        = 1'b0;
		sample_ch.start_req    = 1'b0;
		sample_ch.level_first  = '0;
		sample_ch.level_second = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = aldb_pkg::CFG_IDLE_LEVEL;
		cfg_ch.data            = '0;
		// shadow state matches the block after reset
		keypad_idle     = LEVEL_TOP;
		keypad_confirm  = 8'd3;
		keypad_window   = 16'd100;
		keypad_quick    = 16'd20;
		keypad_pairs[0] = '0;
		keypad_pairs[1] = '0;
		keypad_pairs[2] = '0;
		sess_open       = 1'b0;
		last_code       = aldb_pkg::BTN_NONE;
		run_len         = '0;
		sample_pos      = '0;
		fail_count      = 0;
		cycle_count     = 0;
		in_idle_on      = 1'b1;
		out_idle_on     = 1'b1;
		arst_n          = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_ladder_codes();
		test_restart();
		test_quick_exit();
		test_timeout();
		test_window_extremes();
		test_random_ladder();
		test_random_tables();
		test_long_confirm();
		test_random_mix();

		wait_drain();
		if (expected_outcomes.size() != 0) begin
			fail_count++;
			$display("%0d expected result beats never arrived", expected_outcomes.size());
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### adc_ladder_button_debounce_unit.f
rtl/aldb_pkg.sv
rtl/aldb_if.sv
rtl/aldb_front.sv
rtl/aldb_queue.sv
rtl/aldb_back.sv
rtl/adc_ladder_button_debounce_unit.sv
rtl/aldb_checker.sv
tb/tb_top.sv
